// ===== hdl/psaq_pkg.sv =====
// Shared types and constants for the pedal step assist qualifier.
// Holds the register map, the reset values and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package psaq_pkg;

   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [1:0] {
      REG_FORWARD_TICKS     = 2'd0,
      REG_REVERSE_TICKS     = 2'd1,
      REG_IDLE_LIMIT        = 2'd2,
      REG_REVERSE_DIRECTION = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      DIR_NONE    = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REVERSE = 2'd2
   } dir_type;

   localparam logic [6:0]  FORWARD_TICKS_RST     = 7'd4;
   localparam logic [6:0]  REVERSE_TICKS_RST     = 7'd2;
   localparam logic [15:0] IDLE_LIMIT_RST        = 16'd1000;
   localparam logic        REVERSE_DIRECTION_RST = 1'b1;

   localparam logic [15:0] IDLE_MAX  = 16'hFFFF;
   localparam logic [7:0]  COUNT_MAX = 8'sh7F;
   localparam logic [7:0]  COUNT_MIN = 8'sh80;

   typedef struct packed {
      logic [6:0]  forward_ticks;
      logic [6:0]  reverse_ticks;
      logic [15:0] idle_limit;
      logic        reverse_direction;
   } cfg_type;

endpackage

// ===== hdl/psaq_csr.sv =====
// Configuration register file for the pedal step assist qualifier.
// Decodes the APB-style port and holds the four settings; uses psaq_pkg.
`timescale 1ns / 1ps

module psaq_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [psaq_pkg::ADDR_W-1:0] paddr,
   input  logic [psaq_pkg::DATA_W-1:0] pwdata,
   output logic [psaq_pkg::DATA_W-1:0] prdata,
   output psaq_pkg::cfg_type           cfg
);

   psaq_pkg::cfg_type     cfg_ff;
   psaq_pkg::cfg_type     cfg_in;
   psaq_pkg::reg_idx_type reg_idx;
   logic                  wr_en;

   assign reg_idx = psaq_pkg::reg_idx_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            psaq_pkg::REG_FORWARD_TICKS:     cfg_in.forward_ticks     = pwdata[6:0];
            psaq_pkg::REG_REVERSE_TICKS:     cfg_in.reverse_ticks     = pwdata[6:0];
            psaq_pkg::REG_IDLE_LIMIT:        cfg_in.idle_limit        = pwdata[15:0];
            psaq_pkg::REG_REVERSE_DIRECTION: cfg_in.reverse_direction = pwdata[0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forward_ticks     <= psaq_pkg::FORWARD_TICKS_RST;
         cfg_ff.reverse_ticks     <= psaq_pkg::REVERSE_TICKS_RST;
         cfg_ff.idle_limit        <= psaq_pkg::IDLE_LIMIT_RST;
         cfg_ff.reverse_direction <= psaq_pkg::REVERSE_DIRECTION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         psaq_pkg::REG_FORWARD_TICKS:     prdata = {25'd0, cfg_ff.forward_ticks};
         psaq_pkg::REG_REVERSE_TICKS:     prdata = {25'd0, cfg_ff.reverse_ticks};
         psaq_pkg::REG_IDLE_LIMIT:        prdata = {16'd0, cfg_ff.idle_limit};
         psaq_pkg::REG_REVERSE_DIRECTION: prdata = {31'd0, cfg_ff.reverse_direction};
         default:                         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/pedal_step_assist_qualifier_core.sv =====
// Top level of the pedal step assist qualifier: input word register, step
// qualification logic, state and result register. Uses psaq_pkg and psaq_csr.
`timescale 1ns / 1ps

// The block takes one signed step delta per word on the req_ channel and
// returns one result word on the rsp_ channel: the assist level, the LED
// level and the direction of the step. Both channels move a word at a rising
// edge where valid is high and stall is low.
// An accepted word lands in an input register; it is then qualified against
// the step count, idle count and assist flag and written to the result
// register once that register is empty or its word is taken by the receiver.
// One word per cycle is sustained while the receiver does not stall; the
// single update path from the input to the result register sets that figure.
// When the receiver stalls, the result register holds its word and the input
// register can still take one more word before req_stall rises.
// Reset clears both valid flags, the step and idle counts and the assist
// flag, and loads the default settings. The user must write the settings
// over APB only while no word is in flight; the block does not enforce it.

module pedal_step_assist_qualifier_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [3:0]           req_step_delta,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_assist_on,
   output logic                        rsp_led_on,
   output logic [1:0]                  rsp_direction,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [psaq_pkg::ADDR_W-1:0] paddr,
   input  logic [psaq_pkg::DATA_W-1:0] pwdata,
   output logic [psaq_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);

   psaq_pkg::cfg_type cfg;

   logic              in_valid_ff, in_valid_in;
   logic signed [3:0] in_delta_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_assist_ff, rsp_led_ff;
   logic [1:0]        rsp_dir_ff;

   logic signed [7:0] step_count_ff, step_count_in;
   logic [15:0]       idle_count_ff, idle_count_in;
   logic              assist_ff, assist_in;

   logic              accept, advance;
   logic signed [4:0] delta_ext, delta_dir;
   logic signed [8:0] sum_wide;
   logic signed [7:0] step_sat;
   logic              is_fwd, is_rev, idle_over, below_fwd, above_rev;
   psaq_pkg::dir_type dir;

   psaq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign delta_ext = {in_delta_ff[3], in_delta_ff};
   assign delta_dir = cfg.reverse_direction ? -delta_ext : delta_ext;
   assign is_rev    = delta_dir[4];
   assign is_fwd    = !delta_dir[4] && (delta_dir != 5'sd0);

   assign sum_wide  = {step_count_ff[7], step_count_ff} + {{4{delta_dir[4]}}, delta_dir};
   assign step_sat  = (sum_wide[8] != sum_wide[7])
                      ? (sum_wide[8] ? psaq_pkg::COUNT_MIN : psaq_pkg::COUNT_MAX)
                      : sum_wide[7:0];

   assign idle_over = idle_count_ff > cfg.idle_limit;
   assign below_fwd = $signed({step_count_ff[7], step_count_ff}) <
                      $signed({2'b00, cfg.forward_ticks});
   assign above_rev = $signed({step_count_ff[7], step_count_ff}) >
                      $signed({2'b00, cfg.reverse_ticks});

   always_comb begin
      step_count_in = step_count_ff;
      idle_count_in = idle_count_ff;
      assist_in     = assist_ff;
      dir           = psaq_pkg::DIR_NONE;
      priority if (is_fwd) begin
         dir = psaq_pkg::DIR_FORWARD;
         if (idle_over) begin
            idle_count_in = '0;
         end
         if (below_fwd) begin
            step_count_in = step_sat;
         end else begin
            idle_count_in = '0;
            assist_in     = 1'b1;
         end
      end else if (is_rev) begin
         dir = psaq_pkg::DIR_REVERSE;
         if (above_rev) begin
            step_count_in = step_sat;
         end else begin
            assist_in = 1'b0;
         end
      end else begin
         if (idle_over) begin
            step_count_in = '0;
            assist_in     = 1'b0;
         end else if (idle_count_ff != psaq_pkg::IDLE_MAX) begin
            idle_count_in = idle_count_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_count_ff <= '0;
         idle_count_ff <= '0;
         assist_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            step_count_ff <= step_count_in;
            idle_count_ff <= idle_count_in;
            assist_ff     <= assist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_delta_ff <= req_step_delta;
      end
      if (advance) begin
         rsp_assist_ff <= assist_in;
         rsp_led_ff    <= assist_in ^ (dir != psaq_pkg::DIR_NONE);
         rsp_dir_ff    <= dir;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_assist_on = rsp_assist_ff;
   assign rsp_led_on    = rsp_led_ff;
   assign rsp_direction = rsp_dir_ff;

   a_held_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_delta_ff))
      else $error("Input word lost while waiting for the result register.");

   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(step_count_ff) && $stable(idle_count_ff) && $stable(assist_ff))
      else $error("Qualifier state changed without a word moving forward.");

   a_result_flag: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (rsp_assist_ff == assist_ff))
      else $error("Result assist level differs from the assist flag.");

   a_led_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_led_ff == (rsp_assist_ff ^ (rsp_dir_ff != psaq_pkg::DIR_NONE))))
      else $error("LED level does not follow assist level and step.");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_dir_ff == psaq_pkg::DIR_NONE) ||
                       (rsp_dir_ff == psaq_pkg::DIR_FORWARD) ||
                       (rsp_dir_ff == psaq_pkg::DIR_REVERSE))
      else $error("Result carries an unused direction code.");

endmodule

// ===== verif/tb_pedal_step_assist_qualifier_core.sv =====
// Self-checking testbench for pedal_step_assist_qualifier_core: drives step deltas,
// writes the settings over the APB-style port and checks every result word.
// Depends on psaq_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_pedal_step_assist_qualifier_core;

   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD    = 300;
   localparam int BLOCK_WORDS  = 115;

   typedef struct {
      logic              assist;
      logic              led;
      psaq_pkg::dir_type dir;
   } assist_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [3:0]             req_step_delta = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_assist_on;
   logic                          rsp_led_on;
   logic [1:0]                    rsp_direction;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [psaq_pkg::ADDR_W-1:0]   paddr = '0;
   logic [psaq_pkg::DATA_W-1:0]   pwdata = '0;
   logic [psaq_pkg::DATA_W-1:0]   prdata;
   logic                          pready;

   logic signed [3:0]             pending_deltas[$];
   assist_word_type               predicted_words[$];

   psaq_pkg::cfg_type             shadow_cfg;
   logic signed [7:0]             pred_step_count;
   logic [15:0]                   pred_idle_count;
   logic                          pred_assist;

   int                            tx_idle_pct = 0;
   int                            rx_idle_pct = 0;
   int                            hold_req_cnt = 0;
   int                            hold_ack_cnt = 0;
   int                            hold_left = 0;
   int                            errors = 0;

   pedal_step_assist_qualifier_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_step_delta (req_step_delta),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_assist_on  (rsp_assist_on),
      .rsp_led_on     (rsp_led_on),
      .rsp_direction  (rsp_direction),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #5 clock = ~clock;

   function automatic assist_word_type qualify_step(logic signed [3:0] raw);
      int              delta;
      int              sum;
      assist_word_type w;
      delta = raw;
      if (shadow_cfg.reverse_direction) delta = -delta;
      if (delta > 0) begin
         if (pred_idle_count > shadow_cfg.idle_limit) pred_idle_count = '0;
         if (int'(pred_step_count) < int'(shadow_cfg.forward_ticks)) begin
            sum = int'(pred_step_count) + delta;
            if (sum > 127) sum = 127;
            pred_step_count = sum[7:0];
         end else begin
            pred_idle_count = '0;
            pred_assist = 1'b1;
         end
         w.dir = psaq_pkg::DIR_FORWARD;
      end else if (delta < 0) begin
         if (int'(pred_step_count) > int'(shadow_cfg.reverse_ticks)) begin
            sum = int'(pred_step_count) + delta;
            if (sum < -128) sum = -128;
            pred_step_count = sum[7:0];
         end else begin
            pred_assist = 1'b0;
         end
         w.dir = psaq_pkg::DIR_REVERSE;
      end else begin
         if (pred_idle_count > shadow_cfg.idle_limit) begin
            pred_step_count = '0;
            pred_assist = 1'b0;
         end else if (pred_idle_count < psaq_pkg::IDLE_MAX) begin
            pred_idle_count = pred_idle_count + 16'd1;
         end
         w.dir = psaq_pkg::DIR_NONE;
      end
      w.assist = pred_assist;
      w.led = pred_assist ^ (w.dir != psaq_pkg::DIR_NONE);
      return w;
   endfunction

   always @(posedge clock) begin : driver
      logic              next_valid;
      logic signed [3:0] next_delta;
      next_valid = req_valid;
      next_delta = req_step_delta;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_words.push_back(qualify_step(req_step_delta));
            next_valid = 1'b0;
         end
         if (!next_valid && pending_deltas.size() != 0 &&
             $urandom_range(0, 99) >= tx_idle_pct) begin
            next_valid = 1'b1;
            next_delta = pending_deltas.pop_front();
         end
      end
      req_valid <= next_valid;
      req_step_delta <= next_delta;
   end

   always @(posedge clock) begin : monitor
      logic            stall_next;
      assist_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result word: assist %0b led %0b dir %0d",
                        rsp_assist_on, rsp_led_on, rsp_direction);
         end else begin
            want = predicted_words.pop_front();
            if (rsp_assist_on !== want.assist || rsp_led_on !== want.led ||
                rsp_direction !== want.dir) begin
               errors++;
               if (errors <= 10)
                  $display("result mismatch: expected assist %0b led %0b dir %0d, got %0b %0b %0d",
                           want.assist, want.led, want.dir,
                           rsp_assist_on, rsp_led_on, rsp_direction);
            end
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (hold_req_cnt != hold_ack_cnt) begin
         hold_ack_cnt = hold_req_cnt;
         hold_left = LONG_HOLD;
         stall_next = 1'b1;
      end else begin
         stall_next = ($urandom_range(0, 99) < rx_idle_pct);
      end
      rsp_stall <= stall_next;
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_deltas.size() != 0 || req_valid || predicted_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(psaq_pkg::reg_idx_type idx, logic [psaq_pkg::DATA_W-1:0] value);
      logic [psaq_pkg::DATA_W-1:0] data;
      data = value | ($urandom() & 32'hFFFF_0000);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         psaq_pkg::REG_FORWARD_TICKS:     shadow_cfg.forward_ticks = data[6:0];
         psaq_pkg::REG_REVERSE_TICKS:     shadow_cfg.reverse_ticks = data[6:0];
         psaq_pkg::REG_IDLE_LIMIT:        shadow_cfg.idle_limit = data[15:0];
         psaq_pkg::REG_REVERSE_DIRECTION: shadow_cfg.reverse_direction = data[0];
         default: ;
      endcase
   endtask

   function automatic void push_move(bit forward);
      bit raw_neg;
      int mag;
      raw_neg = (forward == shadow_cfg.reverse_direction);
      mag = raw_neg ? $urandom_range(1, 8) : $urandom_range(1, 7);
      pending_deltas.push_back(4'(raw_neg ? -mag : mag));
   endfunction

   // One run of forward steps, backward steps, idle samples or raw noise.
   function automatic int add_pattern();
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         len = $urandom_range(1, shadow_cfg.forward_ticks / 4 + 4);
         repeat (len) push_move(1'b1);
      end else if (kind < 55) begin
         len = $urandom_range(1, shadow_cfg.reverse_ticks / 4 + 4);
         repeat (len) push_move(1'b0);
      end else if (kind < 80) begin
         if (shadow_cfg.idle_limit <= 40)
            len = $urandom_range(shadow_cfg.idle_limit, shadow_cfg.idle_limit + 3);
         else
            len = $urandom_range(1, 12);
         if (len == 0) len = 1;
         repeat (len) pending_deltas.push_back(4'sd0);
      end else begin
         len = $urandom_range(1, 6);
         repeat (len) pending_deltas.push_back(4'($urandom_range(0, 15)));
      end
      return len;
   endfunction

   task automatic run_block(logic [6:0] fwd, logic [6:0] rev_ticks, logic [15:0] limit,
                            logic rev, bit long_hold);
      int added;
      wait_drained();
      write_reg(psaq_pkg::REG_FORWARD_TICKS, fwd);
      write_reg(psaq_pkg::REG_REVERSE_TICKS, rev_ticks);
      write_reg(psaq_pkg::REG_IDLE_LIMIT, limit);
      write_reg(psaq_pkg::REG_REVERSE_DIRECTION, rev);
      if (long_hold) hold_req_cnt++;
      added = 0;
      while (added < BLOCK_WORDS / 2) added += add_pattern();
      wait_drained();
      while (added < BLOCK_WORDS) added += add_pattern();
   endtask

   task automatic run_random_block();
      run_block(7'($urandom_range(0, 20)), 7'($urandom_range(0, 20)),
                16'($urandom_range(0, 30)), 1'($urandom_range(0, 1)), 1'b0);
   endtask

   initial begin : watchdog
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int directed[] = '{0, -1, -8, -1, -1, 7, 1, 1, -8, -4, -2, 0, 0, 7, 7, 7,
                         -8, -8, -8, 2, 3, 4, 5, 6, -3, 0};
      shadow_cfg.forward_ticks = psaq_pkg::FORWARD_TICKS_RST;
      shadow_cfg.reverse_ticks = psaq_pkg::REVERSE_TICKS_RST;
      shadow_cfg.idle_limit = psaq_pkg::IDLE_LIMIT_RST;
      shadow_cfg.reverse_direction = psaq_pkg::REVERSE_DIRECTION_RST;
      pred_step_count = '0;
      pred_idle_count = '0;
      pred_assist = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 25;
      rx_idle_pct = 56;
      foreach (directed[i]) pending_deltas.push_back(4'(directed[i]));

      run_block(7'd0, 7'd0, 16'd0, 1'b0, 1'b0);
      run_block(7'd127, 7'd127, 16'd65534, 1'b1, 1'b1);
      run_random_block();

      tx_idle_pct = 56;
      rx_idle_pct = 25;
      run_block(7'd127, 7'd0, 16'd5, 1'b0, 1'b0);
      run_block(7'd10, 7'd3, 16'd12, 1'b1, 1'b0);
      run_random_block();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_block(7'd5, 7'd2, 16'd65534, 1'b0, 1'b0);
      run_block(7'd127, 7'd127, 16'd0, 1'b1, 1'b0);
      run_block(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                16'($urandom_range(0, 30)), 1'($urandom_range(0, 1)), 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
